// ===== rtl/damped_particle_integrator_2d_macros.svh =====
// Assertion helpers used by the damped particle integrator controller.
`ifndef DAMPED_PARTICLE_INTEGRATOR_2D_MACROS_SVH
`define DAMPED_PARTICLE_INTEGRATOR_2D_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DPI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dpi_pkg.sv =====
package dpi_pkg;

	localparam logic [1:0] FUNC_FORCE = 2'd0;
	localparam logic [1:0] FUNC_STEP  = 2'd1;
	localparam logic [1:0] FUNC_LDPOS = 2'd2;
	localparam logic [1:0] FUNC_LDVEL = 2'd3;

	localparam logic REG_IMASS = 1'b0;
	localparam logic REG_DAMP  = 1'b1;

	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [16:0] DAMP_RESET  = 17'd64880;
	localparam logic [31:0] ONE_Q30     = 32'd1073741824;

	typedef enum logic [4:0] {
		OP_NOP, OP_FORCE, OP_LDPOS, OP_LDVEL,
		OP_MAX, OP_MAY, OP_MADX, OP_MADY, OP_MPAX, OP_MPAY, OP_MPVX, OP_MPVY,
		OP_UPD, OP_LOGINIT, OP_MSQR, OP_ME, OP_MEXP, OP_FAC,
		OP_MDX, OP_MDY, OP_MQX, OP_MQY, OP_FIN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] idx;
		logic       load_in;
	} dpi_cmd_t;

	typedef struct packed {
		logic vel_nz;
		logic trivial;
	} dpi_status_t;

	typedef logic [15:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		v = n;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-i) in Q2.30, i = 1..16
	function automatic root_tab_t make_roots();
		root_tab_t   tab;
		logic [63:0] root;
		root = 64'h8000_0000;
		for (int i = 0; i < 16; i++) begin
			root = isqrt64(root << 30);
			tab[i] = root[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = make_roots();

endpackage

// ===== rtl/dpi_ctrl.sv =====
`include "damped_particle_integrator_2d_macros.svh"

module dpi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [1:0]           func,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output dpi_pkg::dpi_cmd_t    cmd,
	input  dpi_pkg::dpi_status_t status
);
	import dpi_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_SIMPLE = 11'b000_0000_0010,
		S_ACCEL  = 11'b000_0000_0100,
		S_UPD    = 11'b000_0000_1000,
		S_LINIT  = 11'b000_0001_0000,
		S_LOG    = 11'b000_0010_0000,
		S_ELOG   = 11'b000_0100_0000,
		S_EXP    = 11'b000_1000_0000,
		S_FAC    = 11'b001_0000_0000,
		S_DAMP   = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] func_q, func_d;
	logic       out_valid_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		func_d      = func_q;
		cmd.op      = OP_NOP;
		cmd.idx     = '0;
		cmd.load_in = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					func_d      = func;
					cnt_d       = '0;
					state_d     = (func == FUNC_STEP) ? S_ACCEL : S_SIMPLE;
				end
			end
			S_SIMPLE: begin
				case (func_q)
					FUNC_FORCE: cmd.op = OP_FORCE;
					FUNC_LDPOS: cmd.op = OP_LDPOS;
					FUNC_LDVEL: cmd.op = OP_LDVEL;
					default:    cmd.op = OP_NOP;
				endcase
				state_d = S_FIN;
			end
			S_ACCEL: begin
				// one product a cycle; a dependent product is issued only once its operand is written back
				case (cnt_q[3:0])
					4'd0:    cmd.op = OP_MPVX;
					4'd1:    cmd.op = OP_MPVY;
					4'd2:    cmd.op = OP_MAX;
					4'd3:    cmd.op = OP_MAY;
					4'd4:    cmd.op = OP_MADX;
					4'd5:    cmd.op = OP_MADY;
					4'd6:    cmd.op = OP_MPAX;
					4'd7:    cmd.op = OP_MPAY;
					default: cmd.op = OP_NOP;
				endcase
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd8) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.op  = OP_UPD;
				state_d = S_LINIT;
			end
			S_LINIT: begin
				cmd.op = OP_LOGINIT;
				cnt_d  = '0;
				if (!status.vel_nz) begin
					state_d = S_FIN;
				end else if (status.trivial) begin
					state_d = S_DAMP;
				end else begin
					state_d = S_LOG;
				end
			end
			S_LOG: begin
				cmd.op = cnt_q[0] ? OP_NOP : OP_MSQR;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = S_ELOG;
				end
			end
			S_ELOG: begin
				cmd.op = cnt_q[0] ? OP_NOP : OP_ME;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd1) begin
					cnt_d   = '0;
					state_d = S_EXP;
				end
			end
			S_EXP: begin
				cmd.op  = cnt_q[0] ? OP_NOP : OP_MEXP;
				cmd.idx = cnt_q[4:1];
				cnt_d   = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = S_FAC;
				end
			end
			S_FAC: begin
				cmd.op  = OP_FAC;
				cnt_d   = '0;
				state_d = S_DAMP;
			end
			S_DAMP: begin
				case (cnt_q[2:0])
					3'd0:    cmd.op = OP_MDX;
					3'd1:    cmd.op = OP_MDY;
					3'd2:    cmd.op = OP_MQX;
					3'd3:    cmd.op = OP_MQY;
					default: cmd.op = OP_NOP;
				endcase
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'd4) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			func_q      <= FUNC_FORCE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			func_q  <= func_d;
			if (cmd.op == OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	`DPI_ASSERT_SAME(a_fin_free, cmd.op == OP_FIN, !out_valid_q || m_tready, "result overwritten")
	`DPI_ASSERT_NEXT(a_fin_valid, cmd.op == OP_FIN, m_tvalid, "result not presented")
	`DPI_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "second item taken")
	`DPI_ASSERT_NEXT(a_log_done, state_q == S_LOG && cnt_q == 5'd31, state_q == S_ELOG, "log loop")

endmodule

// ===== rtl/dpi_datapath.sv =====
module dpi_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpi_pkg::dpi_cmd_t    cmd,
	output dpi_pkg::dpi_status_t status,
	input  logic [31:0]          x_value,
	input  logic [31:0]          y_value,
	input  logic [15:0]          time_step,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [23:0]          cfg_data,
	output logic [31:0]          position_x,
	output logic [31:0]          position_y,
	output logic [31:0]          velocity_x,
	output logic [31:0]          velocity_y,
	output logic                 moved
);
	import dpi_pkg::*;

	function automatic logic [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -42'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	logic [23:0] imass_q;
	logic [16:0] damp_q;
	logic [31:0] xin_q, yin_q;
	logic [15:0] dt_q;
	logic [31:0] px_q, py_q, vx_q, vy_q, fx_q, fy_q;
	logic [39:0] ax_q, ay_q, adx_q, ady_q, pax_q, pay_q;
	logic [31:0] pvx_q, pvy_q;
	logic        moved_q;
	logic [30:0] z_q;
	logic [15:0] frac_q;
	logic [4:0]  k_q;
	logic [4:0]  ip_q;
	logic [15:0] f_q;
	logic [31:0] p_q;
	logic [16:0] fac_q;
	logic [62:0] sq_q;

	logic signed [40:0] ma;
	logic signed [32:0] mb;
	logic signed [73:0] prod_q;
	op_t                tag_q;

	logic [16:0]        d_eff;
	logic [4:0]         k_w;
	logic [16:0]        m_w;
	logic signed [21:0] lg_w;
	logic [4:0]         shamt_w;
	logic [31:0]        sqz_w;
	logic [63:0]        sqsum_w;
	logic [31:0]        nx_w, ny_w;

	assign d_eff = (damp_q > ONE_Q16) ? ONE_Q16 : damp_q;

	// normalize damping to [1,2): k is the shift count
	always_comb begin
		k_w = '0;
		for (int i = 0; i < 17; i++) begin
			if (d_eff[i]) begin
				k_w = 5'(16 - i);
			end
		end
	end
	assign m_w     = d_eff << k_w;
	assign lg_w    = $signed({6'b0, frac_q}) - $signed({1'b0, k_q, 16'b0});
	assign shamt_w = 5'd14 - ip_q;
	assign sqz_w   = prod_q[61:30];
	assign sqsum_w = {1'b0, sq_q} + {1'b0, prod_q[62:0]};

	assign nx_w = sat32($signed({{10{px_q[31]}}, px_q}) + $signed({{10{pvx_q[31]}}, pvx_q})
		+ $signed({{2{pax_q[39]}}, pax_q}));
	assign ny_w = sat32($signed({{10{py_q[31]}}, py_q}) + $signed({{10{pvy_q[31]}}, pvy_q})
		+ $signed({{2{pay_q[39]}}, pay_q}));

	assign status.vel_nz  = |{vx_q, vy_q};
	assign status.trivial = (dt_q == '0) || (d_eff == '0);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MAX:  begin ma = {{9{fx_q[31]}}, fx_q}; mb = {9'b0, imass_q}; end
			OP_MAY:  begin ma = {{9{fy_q[31]}}, fy_q}; mb = {9'b0, imass_q}; end
			OP_MADX: begin ma = {ax_q[39], ax_q}; mb = {17'b0, dt_q}; end
			OP_MADY: begin ma = {ay_q[39], ay_q}; mb = {17'b0, dt_q}; end
			OP_MPAX: begin ma = {adx_q[39], adx_q}; mb = {17'b0, dt_q}; end
			OP_MPAY: begin ma = {ady_q[39], ady_q}; mb = {17'b0, dt_q}; end
			OP_MPVX: begin ma = {{9{vx_q[31]}}, vx_q}; mb = {17'b0, dt_q}; end
			OP_MPVY: begin ma = {{9{vy_q[31]}}, vy_q}; mb = {17'b0, dt_q}; end
			OP_MSQR: begin ma = {10'b0, z_q}; mb = {2'b0, z_q}; end
			OP_ME:   begin ma = {25'b0, dt_q}; mb = {{11{lg_w[21]}}, lg_w}; end
			OP_MEXP: begin
				ma = {9'b0, p_q};
				mb = f_q[4'd15 - cmd.idx] ? {1'b0, ROOT_TAB[cmd.idx]} : {1'b0, ONE_Q30};
			end
			OP_MDX:  begin ma = {{9{vx_q[31]}}, vx_q}; mb = {16'b0, fac_q}; end
			OP_MDY:  begin ma = {{9{vy_q[31]}}, vy_q}; mb = {16'b0, fac_q}; end
			OP_MQX:  begin ma = {{9{vx_q[31]}}, vx_q}; mb = {vx_q[31], vx_q}; end
			OP_MQY:  begin ma = {{9{vy_q[31]}}, vy_q}; mb = {vy_q[31], vy_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= OP_NOP;
			imass_q <= '0;
			damp_q  <= DAMP_RESET;
			px_q    <= '0;
			py_q    <= '0;
			vx_q    <= '0;
			vy_q    <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			moved_q <= 1'b0;
		end else begin
			tag_q <= cmd.op;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMASS: imass_q <= cfg_data;
					REG_DAMP:  damp_q  <= cfg_data[16:0];
					default:   imass_q <= imass_q;
				endcase
			end

			// issue-side ops
			case (cmd.op)
				OP_FORCE: begin
					fx_q    <= sat32($signed({{10{fx_q[31]}}, fx_q})
						+ $signed({{10{xin_q[31]}}, xin_q}));
					fy_q    <= sat32($signed({{10{fy_q[31]}}, fy_q})
						+ $signed({{10{yin_q[31]}}, yin_q}));
					moved_q <= 1'b0;
				end
				OP_LDPOS: begin
					px_q    <= xin_q;
					py_q    <= yin_q;
					moved_q <= 1'b0;
				end
				OP_LDVEL: begin
					vx_q    <= xin_q;
					vy_q    <= yin_q;
					moved_q <= 1'b0;
				end
				OP_UPD: begin
					moved_q <= (nx_w != px_q) || (ny_w != py_q);
					px_q    <= nx_w;
					py_q    <= ny_w;
					vx_q    <= sat32($signed({{10{vx_q[31]}}, vx_q})
						+ $signed({{2{adx_q[39]}}, adx_q}));
					vy_q    <= sat32($signed({{10{vy_q[31]}}, vy_q})
						+ $signed({{2{ady_q[39]}}, ady_q}));
					fx_q    <= '0;
					fy_q    <= '0;
				end
				default: begin
				end
			endcase

			// product write-back, from the registered product selected by its registered tag
			case (tag_q)
				OP_MDX: vx_q <= prod_q[47:16];
				OP_MDY: vy_q <= prod_q[47:16];
				OP_MQY: begin
					// speed squared below one stops the particle
					if (sqsum_w[63:32] == '0) begin
						vx_q <= '0;
						vy_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			xin_q <= x_value;
			yin_q <= y_value;
			dt_q  <= time_step;
		end
		case (cmd.op)
			OP_LOGINIT: begin
				z_q    <= {m_w, 14'b0};
				k_q    <= k_w;
				frac_q <= '0;
				p_q    <= ONE_Q30;
				fac_q  <= (dt_q == '0) ? ONE_Q16 : 17'd0;
			end
			OP_FAC:  fac_q <= 17'(p_q >> shamt_w);
			OP_FIN: begin
				position_x <= px_q;
				position_y <= py_q;
				velocity_x <= vx_q;
				velocity_y <= vy_q;
				moved      <= moved_q;
			end
			default: begin
			end
		endcase
		case (tag_q)
			OP_MAX:  ax_q  <= prod_q[55:16];
			OP_MAY:  ay_q  <= prod_q[55:16];
			OP_MADX: adx_q <= prod_q[55:16];
			OP_MADY: ady_q <= prod_q[55:16];
			OP_MPAX: pax_q <= prod_q[56:17];
			OP_MPAY: pay_q <= prod_q[56:17];
			OP_MPVX: pvx_q <= prod_q[47:16];
			OP_MPVY: pvy_q <= prod_q[47:16];
			OP_MSQR: begin
				if (sqz_w[31]) begin
					z_q    <= sqz_w[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					z_q    <= sqz_w[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			OP_ME: begin
				ip_q <= prod_q[36:32];
				f_q  <= prod_q[31:16];
			end
			OP_MEXP: p_q  <= prod_q[61:30];
			OP_MQX:  sq_q <= prod_q[62:0];
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/damped_particle_integrator_2d.sv =====
// Damped 2D point-mass integrator in Q16.16. One item in, one result out. Add-force,
// load-position and load-velocity items go from acceptance to their operation and then
// to the finish state, which registers the result. A time step skips the damping stage
// when the velocity ends at zero and the log2 and exp2 loops when damping is trivial
// (zero time step or zero damping). Every product goes through one shared 41x33
// multiplier, and the 16 log2 squarings and 16 exp2 root products are dependent, each
// issued only once the previous one is written back. Input is taken only while no item is
// in work. A finished result waits in the output register and does not block the next item
// from being taken, but that item's result enters the output register only once the
// previous one has been taken, adding the cycles spent waiting on m_tready. Configuration
// writes apply at once and are to be made while the block is idle; it does not enforce that.
module damped_particle_integrator_2d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // x_value, y_value, time_step
	input  logic [1:0]   s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // position_x, position_y, velocity_x, velocity_y
	output logic [0:0]   m_tuser,   // moved
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [23:0]  cfg_data
);
	import dpi_pkg::*;

	dpi_cmd_t    cmd;
	dpi_status_t status;
	logic        moved;

	dpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	dpi_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.x_value    (s_tdata[31:0]),
		.y_value    (s_tdata[63:32]),
		.time_step  (s_tdata[79:64]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.position_x (m_tdata[31:0]),
		.position_y (m_tdata[63:32]),
		.velocity_x (m_tdata[95:64]),
		.velocity_y (m_tdata[127:96]),
		.moved      (moved)
	);

	assign m_tuser[0] = moved;

endmodule
